// File: rtl/mtt_pkg.sv
// shared types, constants and codes for the multi timer table
// no dependencies; every other rtl file imports this package
`default_nettype none

package mtt_pkg;

    // table geometry
    localparam int NUM_TIMERS = 16;
    localparam int TAG_WIDTH  = 16;
    localparam int SLOT_W     = $clog2(NUM_TIMERS);

    // fixed field widths of the transaction payloads
    localparam int OP_W      = 2;
    localparam int TIME_W    = 32;
    localparam int ID_W      = 4;
    localparam int TAG_FLD_W = 16;
    localparam int KIND_W    = 3;

    // queue depths, both powers of two so the pointers wrap naturally
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

    // operation codes
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STARTED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOPPED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOTFOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd5;

    // input transaction as seen on the ports
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [TIME_W-1:0]    delay_ms;
        logic [ID_W-1:0]      timer_id;
        logic [TAG_FLD_W-1:0] event_tag;
    } in_item_t;

    // result transaction as seen on the ports
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ID_W-1:0]      timer_id_res;
        logic [TAG_FLD_W-1:0] event_tag_res;
        logic                 last;
    } out_item_t;

    // classified command held between front and back
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [TIME_W-1:0]    delay_ms;
        logic [ID_W-1:0]      timer_id;
        logic [TAG_WIDTH-1:0] tag;
    } cmd_item_t;

    // command queue head as offered to the back end
    typedef struct packed {
        logic      valid;
        cmd_item_t item;
    } cmd_head_t;

    // result write from the back end into the result queue
    typedef struct packed {
        logic      wr;
        out_item_t item;
    } res_wr_t;

endpackage

`default_nettype wire

// File: rtl/mtt_front.sv
// front end: accepts input transactions, drops unused op codes, queues commands
// depends on mtt_pkg
`default_nettype none

module mtt_front
    import mtt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire in_item_t  cmd,
    output cmd_head_t      head,
    input  wire logic      take
);

    cmd_item_t              entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]       count_reg, count_next;
    logic                   accept;
    logic                   enq;
    logic                   deq;
    cmd_item_t              cls_item;

    // classify: only real operations enter the queue
    assign full     = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign accept   = push && !full;
    assign enq      = accept && (cmd.op != OP_NONE);
    assign deq      = take && head.valid;

    always_comb
    begin
        cls_item.op         = cmd.op;
        cls_item.delay_ms   = cmd.delay_ms;
        cls_item.timer_id   = cmd.timer_id;
        cls_item.tag        = TAG_WIDTH'(cmd.event_tag);
    end

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + CMDQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + CMDQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + (CMDQ_AW+1)'(1);
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - (CMDQ_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wr_ptr_reg] <= cls_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: rtl/mtt_back.sv
// back end: timer slot state and the sequencer that carries out commands
// depends on mtt_pkg
`default_nettype none

module mtt_back
    import mtt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_head_t head,
    output logic           take,
    output res_wr_t        res,
    input  wire logic      res_full
);

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_START    = 2'd1;
    localparam logic [1:0] ST_TICK     = 2'd2;
    localparam logic [1:0] ST_TICK_END = 2'd3;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);

    logic [1:0]              state_reg, state_next;
    logic [SLOT_W-1:0]       cur_reg, cur_next;
    logic [SLOT_W-1:0]       cnt_reg, cnt_next;
    logic [SLOT_W-1:0]       alloc_reg, alloc_next;
    logic [NUM_TIMERS-1:0]   active_reg, active_next;
    cmd_item_t               cmd_reg, cmd_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]       pend_id_reg, pend_id_next;
    logic [TAG_WIDTH-1:0]    pend_tag_reg, pend_tag_next;

    logic [TIME_W-1:0]       rem_reg [NUM_TIMERS];
    logic [TAG_WIDTH-1:0]    tag_reg [NUM_TIMERS];
    logic                    rem_we;
    logic [TIME_W-1:0]       rem_wdata;
    logic                    tag_we;

    logic [SLOT_W-1:0]       cur_inc;
    logic [SLOT_W-1:0]       stop_idx;
    logic                    stop_hit;
    logic [TIME_W-1:0]       cur_rem;
    logic                    cur_expires;
    logic                    step;

    assign cur_inc     = (cur_reg == LAST_SLOT) ? '0 : cur_reg + SLOT_W'(1);
    assign stop_idx    = SLOT_W'(head.item.timer_id);
    assign stop_hit    = (32'(head.item.timer_id) < NUM_TIMERS) && active_reg[stop_idx];
    assign cur_rem     = rem_reg[cur_reg];
    assign cur_expires = active_reg[cur_reg] && (cur_rem <= 32'd1);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        alloc_next      = alloc_reg;
        active_next     = active_reg;
        cmd_next        = cmd_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_tag_next   = pend_tag_reg;
        take            = 1'b0;
        res             = '0;
        rem_we          = 1'b0;
        rem_wdata       = cmd_reg.delay_ms;
        tag_we          = 1'b0;
        step            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    case (head.item.op)
                        OP_START:
                        begin
                            take       = 1'b1;
                            cmd_next   = head.item;
                            cur_next   = alloc_reg;
                            cnt_next   = '0;
                            state_next = ST_START;
                        end
                        OP_STOP:
                        begin
                            if (!res_full)
                            begin
                                take                  = 1'b1;
                                res.wr                = 1'b1;
                                res.item.timer_id_res = head.item.timer_id;
                                res.item.last         = 1'b1;
                                if (stop_hit)
                                begin
                                    res.item.kind         = KIND_STOPPED;
                                    active_next[stop_idx] = 1'b0;
                                end
                                else
                                begin
                                    res.item.kind = KIND_NOTFOUND;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            take            = 1'b1;
                            cur_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_TICK;
                        end
                        default:
                        begin
                            take = 1'b1;
                        end
                    endcase
                end
            end

            // search for a free slot from the rotating pointer
            ST_START:
            begin
                if (!active_reg[cur_reg])
                begin
                    if (!res_full)
                    begin
                        res.wr                = 1'b1;
                        res.item.kind         = KIND_STARTED;
                        res.item.timer_id_res = ID_W'(cur_reg);
                        res.item.last         = 1'b1;
                        active_next[cur_reg]  = 1'b1;
                        rem_we                = 1'b1;
                        tag_we                = 1'b1;
                        alloc_next            = cur_reg;
                        state_next            = ST_IDLE;
                    end
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    if (!res_full)
                    begin
                        res.wr        = 1'b1;
                        res.item.kind = KIND_FULL;
                        res.item.last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    cur_next = cur_inc;
                    cnt_next = cnt_reg + SLOT_W'(1);
                end
            end

            // walk all slots; hold back one expiry so the final one gets last
            ST_TICK:
            begin
                if (cur_expires)
                begin
                    if (!(pend_valid_reg && res_full))
                    begin
                        if (pend_valid_reg)
                        begin
                            res.wr                 = 1'b1;
                            res.item.kind          = KIND_EXPIRED;
                            res.item.timer_id_res  = ID_W'(pend_id_reg);
                            res.item.event_tag_res = TAG_FLD_W'(pend_tag_reg);
                        end
                        pend_valid_next      = 1'b1;
                        pend_id_next         = cur_reg;
                        pend_tag_next        = tag_reg[cur_reg];
                        active_next[cur_reg] = 1'b0;
                        step                 = 1'b1;
                    end
                end
                else
                begin
                    if (active_reg[cur_reg])
                    begin
                        rem_we    = 1'b1;
                        rem_wdata = cur_rem - 32'd1;
                    end
                    step = 1'b1;
                end
                if (step)
                begin
                    if (cur_reg == LAST_SLOT)
                    begin
                        state_next = ST_TICK_END;
                    end
                    else
                    begin
                        cur_next = cur_reg + SLOT_W'(1);
                    end
                end
            end

            ST_TICK_END:
            begin
                if (!res_full)
                begin
                    res.wr        = 1'b1;
                    res.item.last = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res.item.kind          = KIND_EXPIRED;
                        res.item.timer_id_res  = ID_W'(pend_id_reg);
                        res.item.event_tag_res = TAG_FLD_W'(pend_tag_reg);
                    end
                    else
                    begin
                        res.item.kind = KIND_NONE;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            cnt_reg        <= '0;
            alloc_reg      <= '0;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            cnt_reg        <= cnt_next;
            alloc_reg      <= alloc_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pend_id_reg  <= pend_id_next;
        pend_tag_reg <= pend_tag_next;
    end

    // slot remaining time and tag, one write port at the current slot
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_reg[cur_reg] <= rem_wdata;
        end
        if (tag_we)
        begin
            tag_reg[cur_reg] <= cmd_reg.tag;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mtt_res_queue.sv
// result queue: holds finished results until the consumer pops them
// depends on mtt_pkg
`default_nettype none

module mtt_res_queue
    import mtt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire res_wr_t   res,
    output logic           res_full,
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      result
);

    out_item_t              entry_reg [RESQ_DEPTH];
    logic [RESQ_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [RESQ_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [RESQ_AW:0]       count_reg, count_next;
    logic                   deq;

    assign res_full = (count_reg == (RESQ_AW+1)'(RESQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign deq      = pop && !empty;
    assign result   = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = res.wr ? wr_ptr_reg + RESQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + RESQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (res.wr && !deq)
        begin
            count_next = count_reg + (RESQ_AW+1)'(1);
        end
        else if (deq && !res.wr)
        begin
            count_next = count_reg - (RESQ_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (res.wr)
        begin
            entry_reg[wr_ptr_reg] <= res.item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/multi_timer_table_unit.sv
// top level of the multi timer table: front end, back end and result queue
// depends on mtt_pkg, mtt_front, mtt_back, mtt_res_queue
//
// A table of NUM_TIMERS one-shot millisecond timers behind two queue-style
// ports. A start transaction takes the first free slot searching upward from
// the slot last assigned, a stop frees a slot, and a tick ages every active
// timer by one and reports each one that runs out in ascending slot order
// (or one none-expired result), with last set on the final result. Commands
// enter a two-entry queue and a sequencer steps through the slots one per
// cycle while the result queue (four entries) has room. A stop is handled
// from idle, a start probes slots until one is free or all are seen, a tick
// visits every slot and then writes its final result. New commands are
// accepted while earlier ones are in progress until the command queue fills.
`default_nettype none

module multi_timer_table_unit
    import mtt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire in_item_t  cmd,
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      result
);

    cmd_head_t  head;
    logic       take;
    res_wr_t    res;
    logic       res_full;

    // accept and classify
    mtt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .cmd   (cmd),
        .head  (head),
        .take  (take)
    );

    // slot table and sequencer
    mtt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .take     (take),
        .res      (res),
        .res_full (res_full)
    );

    // result buffering
    mtt_res_queue u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

`default_nettype wire

// File: rtl/mtt_checker.sv
// port-level checks for the multi timer table, bound to the top level
// depends on mtt_pkg and multi_timer_table_unit
`default_nettype none

module mtt_checker
    import mtt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      empty,
    input  wire logic      pop,
    input  wire out_item_t result
);

    // only a tick expiry may leave more results to follow
    a_last_on_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_EXPIRED) |-> result.last)
        else $error("non-expiry result without last");

    // tags come back only with an expiry
    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_EXPIRED) |-> (result.event_tag_res == '0))
        else $error("nonzero tag on non-expiry result");

    // none-expired and table-full results carry slot zero
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_NONE || result.kind == KIND_FULL))
        |-> (result.timer_id_res == '0))
        else $error("nonzero slot on none-expired or full result");

    // a waiting result holds until popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

endmodule

bind multi_timer_table_unit mtt_checker u_mtt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for multi_timer_table_unit: queue-style driver and monitor
// depends on mtt_pkg for payload types, op codes and result kinds, and on the rtl top
// a cycle-free model of the timer table predicts every result transaction in order

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtt_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 148;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      full;
    in_item_t  cmd   = '0;
    logic      empty;
    logic      pop   = 1'b0;
    out_item_t result;

    in_item_t  cmds_to_send [$];
    out_item_t results_owed [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // shadow copy of the timer table
    logic                 slot_busy  [NUM_TIMERS] = '{default: 1'b0};
    logic [TIME_W-1:0]    slot_left  [NUM_TIMERS] = '{default: '0};
    logic [TAG_WIDTH-1:0] slot_token [NUM_TIMERS] = '{default: '0};
    int                   next_slot = 0;

    always #5 clk = ~clk;

    multi_timer_table_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .cmd    (cmd),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    function automatic out_item_t make_result(input logic [KIND_W-1:0] kind, input int slot,
                                              input logic [TAG_FLD_W-1:0] tag,
                                              input logic last_flag);
        out_item_t r;
        r               = '0;
        r.kind          = kind;
        r.timer_id_res  = slot[ID_W-1:0];
        r.event_tag_res = tag;
        r.last          = last_flag;
        return r;
    endfunction

    // append one expected result at the tail of the owed list
    task automatic owe_result(input out_item_t r);
        results_owed.insert(results_owed.size(), r);
    endtask

    // apply one accepted command to the shadow table and queue the results it owes
    task automatic timer_table_step(input in_item_t c);
        int s;
        int final_slot;
        bit placed;
        case (c.op)
            OP_START:
            begin
                placed = 1'b0;
                for (int i = 0; i < NUM_TIMERS && !placed; i++)
                begin
                    s = (next_slot + i) % NUM_TIMERS;
                    if (!slot_busy[s])
                    begin
                        slot_busy[s]  = 1'b1;
                        slot_left[s]  = c.delay_ms;
                        slot_token[s] = c.event_tag[TAG_WIDTH-1:0];
                        next_slot     = s;
                        placed        = 1'b1;
                        owe_result(make_result(KIND_STARTED, s, '0, 1'b1));
                    end
                end
                if (!placed)
                    owe_result(make_result(KIND_FULL, 0, '0, 1'b1));
            end
            OP_STOP:
            begin
                if (int'(c.timer_id) < NUM_TIMERS && slot_busy[c.timer_id])
                begin
                    slot_busy[c.timer_id] = 1'b0;
                    owe_result(make_result(KIND_STOPPED, int'(c.timer_id), '0, 1'b1));
                end
                else
                    owe_result(make_result(KIND_NOTFOUND, int'(c.timer_id), '0, 1'b1));
            end
            OP_TICK:
            begin
                // find the highest slot that runs out, it carries the last mark
                final_slot = -1;
                for (int i = 0; i < NUM_TIMERS; i++)
                    if (slot_busy[i] && slot_left[i] <= 1)
                        final_slot = i;
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (slot_busy[i])
                    begin
                        if (slot_left[i] <= 1)
                        begin
                            slot_busy[i] = 1'b0;
                            owe_result(make_result(KIND_EXPIRED, i,
                                TAG_FLD_W'(slot_token[i]), i == final_slot));
                        end
                        else
                            slot_left[i] = slot_left[i] - 1;
                    end
                end
                if (final_slot < 0)
                    owe_result(make_result(KIND_NONE, 0, '0, 1'b1));
            end
            default:
            begin
                // unused op code is dropped without a result
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // compare one popped result against the oldest owed one
    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (results_owed.size() == 0)
            report_mismatch($sformatf("unexpected result kind %0d id %0d tag %h last %b",
                got.kind, got.timer_id_res, got.event_tag_res, got.last));
        else
        begin
            want = results_owed.pop_front();
            if (got.kind !== want.kind || got.timer_id_res !== want.timer_id_res ||
                got.event_tag_res !== want.event_tag_res || got.last !== want.last)
                report_mismatch($sformatf(
                    "got kind %0d id %0d tag %h last %b, want kind %0d id %0d tag %h last %b",
                    got.kind, got.timer_id_res, got.event_tag_res, got.last,
                    want.kind, want.timer_id_res, want.event_tag_res, want.last));
        end
    endtask

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] timeout,
                             input logic [ID_W-1:0] id, input logic [TAG_FLD_W-1:0] tag);
        in_item_t c;
        c.op         = op;
        c.delay_ms   = timeout;
        c.timer_id   = id;
        c.event_tag  = tag;
        cmds_to_send.insert(cmds_to_send.size(), c);
    endtask

    // driver: predict on every accepted transaction, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            cmd  <= '0;
        end
        else
        begin
            if (push && !full)
                timer_table_step(cmd);
            if (!push || !full)
            begin
                if (cmds_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    cmd  <= cmds_to_send.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: check every popped result, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                check_result(result);
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // cycles since the last transaction on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb failed");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        in_item_t c;
        int pick;
        int burst_left;
        int made;
        int s;
        int first;

        // directed: extreme fields, stop hit and miss, unused op, expiry and a full table
        queue_cmd(OP_START, 32'd0, 4'd0, 16'hFFFF);
        queue_cmd(OP_START, 32'hFFFF_FFFF, 4'd15, 16'h0000);
        queue_cmd(OP_STOP, 32'd0, 4'd1, 16'h0000);
        queue_cmd(OP_STOP, 32'hFFFF_FFFF, 4'd1, 16'hFFFF);
        queue_cmd(OP_NONE, 32'hFFFF_FFFF, 4'd15, 16'hFFFF);
        queue_cmd(OP_TICK, 32'd0, 4'd0, 16'h0000);
        queue_cmd(OP_TICK, 32'hFFFF_FFFF, 4'd15, 16'hFFFF);
        for (int i = 0; i < NUM_TIMERS; i++)
            queue_cmd(OP_START, TIME_W'(i % 2), ID_W'($urandom_range(15)),
                      TAG_FLD_W'($urandom_range(65535)));
        queue_cmd(OP_START, 32'd5, 4'd3, 16'h1234);
        queue_cmd(OP_TICK, 32'd0, 4'd0, 16'h0000);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // random part in four idling phases
        burst_left = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            made = 0;
            while (made < RANDOM_ITEMS / 4)
            begin
                while (cmds_to_send.size() > 1)
                    @(posedge clk);
                c.op         = OP_W'($urandom_range(3));
                c.delay_ms   = $urandom;
                c.timer_id   = ID_W'($urandom_range(15));
                c.event_tag  = TAG_FLD_W'($urandom_range(65535));
                pick = $urandom_range(99);
                if (burst_left > 0)
                begin
                    c.op = OP_START;
                    burst_left--;
                end
                else if (pick < 8)
                begin
                    // run of starts to push the table toward full
                    burst_left = $urandom_range(12, 4);
                    c.op = OP_START;
                end
                else if (pick < 38)
                    c.op = OP_START;
                else if (pick < 56)
                    c.op = OP_STOP;
                else if (pick < 95)
                    c.op = OP_TICK;
                else
                    c.op = OP_NONE;
                // mostly short timeouts so timers keep expiring
                if (c.op == OP_START)
                begin
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5, 6: c.delay_ms = $urandom_range(6);
                        7: c.delay_ms = $urandom_range(40, 7);
                        8: c.delay_ms = $urandom;
                        default: c.delay_ms = 32'hFFFF_FFFF;
                    endcase
                end
                // most stops aim at a running timer
                if (c.op == OP_STOP && $urandom_range(3) != 0)
                begin
                    first = $urandom_range(NUM_TIMERS - 1);
                    for (int i = NUM_TIMERS - 1; i >= 0; i--)
                    begin
                        s = (first + i) % NUM_TIMERS;
                        if (slot_busy[s])
                            c.timer_id = ID_W'(s);
                    end
                end
                cmds_to_send.insert(cmds_to_send.size(), c);
                if (c.op != OP_NONE)
                    made++;
            end
        end

        // drain everything, then give stray results time to show up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (cmds_to_send.size() != 0 || push)
            @(posedge clk);
        while (results_owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: files.f
rtl/mtt_pkg.sv
rtl/mtt_front.sv
rtl/mtt_back.sv
rtl/mtt_res_queue.sv
rtl/multi_timer_table_unit.sv
rtl/mtt_checker.sv
tb/tb.sv
